@@ src/tabq_pkg.sv @@
`default_nettype none
package tabq_pkg;

    localparam int FRAC_BITS         = 14;   // fraction bits of the normalised projection
    localparam int IN_FRAC           = 14;   // fraction bits of the body up vector
    localparam int CORDIC_ITERATIONS = 16;
    localparam int TABLE_LEN         = 24;
    localparam int CORDIC_STEPS      = (CORDIC_ITERATIONS < TABLE_LEN) ?
                                       CORDIC_ITERATIONS : TABLE_LEN;
    localparam int SQRT_STEPS        = 32;
    localparam int DIV_STEPS         = FRAC_BITS + 2;
    localparam int OUT_SHIFT         = 15;

    // derived widths
    localparam int T_W    = FRAC_BITS + 2;   // normalised component, signed
    localparam int DACC_W = T_W + 18;        // t.u accumulator
    localparam int CACC_W = T_W + 35;        // t.(u x w) accumulator
    localparam int CRD_W  = T_W + 4;         // CORDIC x/y
    localparam int REM_W  = 32 + FRAC_BITS + 2;

    localparam logic signed [31:0] RIGHT_ANGLE    = 32'sd377487360;
    localparam logic signed [31:0] STRAIGHT_ANGLE = 32'sd754974720;

    localparam logic signed [15:0] TARGET_RESET  = 16'sd0;
    localparam logic [14:0]        ENGAGE_RESET  = 15'd1280;
    localparam logic [14:0]        RELEASE_RESET = 15'd5760;

    localparam logic [1:0] CFG_TARGET  = 2'd0;
    localparam logic [1:0] CFG_ENGAGE  = 2'd1;
    localparam logic [1:0] CFG_RELEASE = 2'd2;

    // multiplier programme; each entry's product is registered in prod_reg, then written to its destination register
    typedef enum logic [4:0] {
        MOP_NONE,
        MOP_WZWX, MOP_WZWY, MOP_WXWX, MOP_WYWY,
        MOP_P0SQ, MOP_P1SQ, MOP_P2SQ, MOP_A_END,
        MOP_UYWZ, MOP_UZWY, MOP_UZWX, MOP_UXWZ, MOP_UXWY, MOP_UYWX,
        MOP_T0U0, MOP_T1U1, MOP_T2U2, MOP_T0V0, MOP_T1V1, MOP_T2V2,
        MOP_XCLAMP, MOP_XX
    } mop_t;

    typedef struct packed {
        logic       load;
        mop_t       mop;
        logic       sqrt_load;
        logic       sqrt_sel_s;
        logic       sqrt_step;
        logic       div_load;
        logic       div_step;
        logic [1:0] div_idx;
        logic       t_write;
        logic       cordic_load;
        logic       cordic_step;
        logic [4:0] step;
        logic       angle_load;
        logic       finish;
    } tabq_cmd_t;

    typedef struct packed {
        logic degen_in;
    } tabq_sts_t;

    // arctan(2^-i) in 2^-22 degree
    function automatic logic signed [31:0] atan_entry(input logic [4:0] i);
        logic signed [31:0] r;
        case (i)
            5'd0:  r = 32'sd188743680;
            5'd1:  r = 32'sd111421900;
            5'd2:  r = 32'sd58872272;
            5'd3:  r = 32'sd29884485;
            5'd4:  r = 32'sd15000234;
            5'd5:  r = 32'sd7507429;
            5'd6:  r = 32'sd3754631;
            5'd7:  r = 32'sd1877430;
            5'd8:  r = 32'sd938729;
            5'd9:  r = 32'sd469366;
            5'd10: r = 32'sd234683;
            5'd11: r = 32'sd117342;
            5'd12: r = 32'sd58671;
            5'd13: r = 32'sd29335;
            5'd14: r = 32'sd14668;
            5'd15: r = 32'sd7334;
            5'd16: r = 32'sd3667;
            5'd17: r = 32'sd1833;
            5'd18: r = 32'sd917;
            5'd19: r = 32'sd458;
            5'd20: r = 32'sd229;
            5'd21: r = 32'sd115;
            5'd22: r = 32'sd57;
            5'd23: r = 32'sd29;
            default: r = 32'sd0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

@@ src/tabq_sqrt.sv @@
`default_nettype none
module tabq_sqrt
    import tabq_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        load,
    input  wire logic        step,
    input  wire logic [4:0]  k,
    input  wire logic [63:0] din,
    output logic      [31:0] root
);

    logic [63:0] v_reg;
    logic [63:0] r_reg;
    logic [63:0] bit_w;
    logic [63:0] trial;

    // one result bit per step, test bit walks down from 2^62
    assign bit_w = 64'd1 << (6'd62 - {k, 1'b0});
    assign trial = r_reg + bit_w;
    assign root  = r_reg[31:0];

    always_ff @(posedge aclk) begin
        if (load) begin
            v_reg <= din;
            r_reg <= '0;
        end else if (step) begin
            if (v_reg >= trial) begin
                v_reg <= v_reg - trial;
                r_reg <= (r_reg >> 1) + bit_w;
            end else begin
                r_reg <= r_reg >> 1;
            end
        end
    end

endmodule
`default_nettype wire

@@ src/tabq_div.sv @@
`default_nettype none
module tabq_div
    import tabq_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 load,
    input  wire logic                 step,
    input  wire logic [4:0]           k,
    input  wire logic [31:0]          num_abs,
    input  wire logic [31:0]          den,
    output logic      [DIV_STEPS-1:0] quot
);

    logic [REM_W-1:0]     rem_reg;
    logic [DIV_STEPS-1:0] quot_reg;
    logic [REM_W-1:0]     dv;
    logic [4:0]           shamt;

    assign shamt = 5'(DIV_STEPS - 1) - k;
    assign dv    = REM_W'(den) << shamt;
    assign quot  = quot_reg;

    // restoring division of (|p| << F) + n/2 by n, one quotient bit per step
    always_ff @(posedge aclk) begin
        if (load) begin
            rem_reg  <= (REM_W'(num_abs) << FRAC_BITS) + REM_W'(den >> 1);
            quot_reg <= '0;
        end else if (step) begin
            if (rem_reg >= dv) begin
                rem_reg  <= rem_reg - dv;
                quot_reg <= {quot_reg[DIV_STEPS-2:0], 1'b1};
            end else begin
                quot_reg <= {quot_reg[DIV_STEPS-2:0], 1'b0};
            end
        end
    end

endmodule
`default_nettype wire

@@ src/tabq_datapath.sv @@
`default_nettype none
module tabq_datapath
    import tabq_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire tabq_cmd_t   cmd,
    output tabq_sts_t        sts,
    input  wire logic [95:0] s_tdata,
    output logic      [23:0] m_tdata,
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    localparam logic signed [DACC_W-1:0] X_ONE  = DACC_W'(1 << FRAC_BITS);
    localparam logic signed [DACC_W-1:0] X_HALF = DACC_W'(1 << (IN_FRAC - 1));
    localparam logic [63:0]              ONE_SQ = 64'd1 << (2 * FRAC_BITS);

    logic signed [15:0] wx_reg, wy_reg, wz_reg, ux_reg, uy_reg, uz_reg;
    logic               degen_reg;
    logic signed [31:0] p0_reg, p1_reg;
    logic signed [32:0] p2_reg;
    logic [63:0]        acc_reg;
    logic signed [32:0] v0_reg, v1_reg, v2_reg;
    logic signed [T_W-1:0] t_reg [3];
    logic signed [DACC_W-1:0] dacc_reg;
    logic signed [CACC_W-1:0] cacc_reg;
    logic signed [63:0] prod_reg;
    mop_t               mop_d_reg;
    logic signed [T_W-1:0] x_reg;
    logic signed [CRD_W-1:0] cx_reg, cy_reg;
    logic signed [31:0] z_reg;
    logic signed [15:0] tilt_reg;
    logic               div_neg_reg;

    logic signed [15:0] target_reg;
    logic [14:0]        engage_reg;
    logic [14:0]        release_reg;
    logic               flag_reg;

    logic signed [15:0] out_tilt_reg;
    logic               out_bal_reg, out_estop_reg, out_degen_reg;

    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;
    logic [63:0]        sq_din;
    logic [31:0]        sq_root;
    logic [31:0]        div_num;
    logic               div_neg;
    logic [DIV_STEPS-1:0] quot;
    logic signed [T_W-1:0] t_new;
    logic signed [DACC_W-1:0] x_shift, x_clamp;
    logic signed [CRD_W-1:0] s_val;
    logic signed [CRD_W-1:0] cx_sh, cy_sh;
    logic signed [31:0] z_clamp;
    logic [31:0]        z_round;
    logic [15:0]        ang_mag;
    logic signed [16:0] err;
    logic [16:0]        err_abs;
    logic               flag_next;

    assign sts.degen_in = (s_tdata[15:0] == 16'd0) && (s_tdata[31:16] == 16'd0);

    // shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.mop)
            MOP_WZWX: begin mul_a = 33'(wz_reg); mul_b = 33'(wx_reg); end
            MOP_WZWY: begin mul_a = 33'(wz_reg); mul_b = 33'(wy_reg); end
            MOP_WXWX: begin mul_a = 33'(wx_reg); mul_b = 33'(wx_reg); end
            MOP_WYWY: begin mul_a = 33'(wy_reg); mul_b = 33'(wy_reg); end
            MOP_P0SQ: begin mul_a = 33'(p0_reg); mul_b = 33'(p0_reg); end
            MOP_P1SQ: begin mul_a = 33'(p1_reg); mul_b = 33'(p1_reg); end
            MOP_P2SQ: begin mul_a = p2_reg;      mul_b = p2_reg;      end
            MOP_UYWZ: begin mul_a = 33'(uy_reg); mul_b = 33'(wz_reg); end
            MOP_UZWY: begin mul_a = 33'(uz_reg); mul_b = 33'(wy_reg); end
            MOP_UZWX: begin mul_a = 33'(uz_reg); mul_b = 33'(wx_reg); end
            MOP_UXWZ: begin mul_a = 33'(ux_reg); mul_b = 33'(wz_reg); end
            MOP_UXWY: begin mul_a = 33'(ux_reg); mul_b = 33'(wy_reg); end
            MOP_UYWX: begin mul_a = 33'(uy_reg); mul_b = 33'(wx_reg); end
            MOP_T0U0: begin mul_a = 33'(t_reg[0]); mul_b = 33'(ux_reg); end
            MOP_T1U1: begin mul_a = 33'(t_reg[1]); mul_b = 33'(uy_reg); end
            MOP_T2U2: begin mul_a = 33'(t_reg[2]); mul_b = 33'(uz_reg); end
            MOP_T0V0: begin mul_a = 33'(t_reg[0]); mul_b = v0_reg; end
            MOP_T1V1: begin mul_a = 33'(t_reg[1]); mul_b = v1_reg; end
            MOP_T2V2: begin mul_a = 33'(t_reg[2]); mul_b = v2_reg; end
            MOP_XX:   begin mul_a = 33'(x_reg);  mul_b = 33'(x_reg);  end
            default:  begin mul_a = '0; mul_b = '0; end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    assign sq_din = cmd.sqrt_sel_s ? (ONE_SQ - $unsigned(prod_reg)) : acc_reg;

    tabq_sqrt u_sqrt (
        .aclk (aclk),
        .load (cmd.sqrt_load),
        .step (cmd.sqrt_step),
        .k    (cmd.step),
        .din  (sq_din),
        .root (sq_root)
    );

    always_comb begin
        case (cmd.div_idx)
            2'd0:    begin div_num = 32'(p0_reg < 0 ? -p0_reg : p0_reg); div_neg = p0_reg < 0; end
            2'd1:    begin div_num = 32'(p1_reg < 0 ? -p1_reg : p1_reg); div_neg = p1_reg < 0; end
            default: begin div_num = 32'(p2_reg); div_neg = 1'b0; end
        endcase
    end

    tabq_div u_div (
        .aclk    (aclk),
        .load    (cmd.div_load),
        .step    (cmd.div_step),
        .k       (cmd.step),
        .num_abs (div_num),
        .den     (sq_root),
        .quot    (quot)
    );

    assign t_new = div_neg_reg ? -$signed(quot) : $signed(quot);

    // dot product rounded back to F fraction bits, clamped to the acos domain
    assign x_shift = (dacc_reg + X_HALF) >>> IN_FRAC;
    assign x_clamp = (x_shift > X_ONE) ? X_ONE : ((x_shift < -X_ONE) ? -X_ONE : x_shift);

    assign s_val = $signed({1'b0, sq_root[CRD_W-2:0]});
    assign cx_sh = cx_reg >>> cmd.step;
    assign cy_sh = cy_reg >>> cmd.step;

    assign z_clamp = (z_reg < 0) ? 32'sd0 : ((z_reg > STRAIGHT_ANGLE) ? STRAIGHT_ANGLE : z_reg);
    assign z_round = ($unsigned(z_clamp) + (32'd1 << (OUT_SHIFT - 1))) >> OUT_SHIFT;
    assign ang_mag = z_round[15:0];

    assign err     = 17'(tilt_reg) - 17'(target_reg);
    assign err_abs = (err < 0) ? $unsigned(-err) : $unsigned(err);

    always_comb begin
        flag_next = flag_reg;
        if (err_abs < {2'b00, engage_reg}) begin
            flag_next = 1'b1;
        end else if (err_abs > {2'b00, release_reg}) begin
            flag_next = 1'b0;
        end
    end

    // control and configuration state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mop_d_reg   <= MOP_NONE;
            flag_reg    <= 1'b0;
            target_reg  <= TARGET_RESET;
            engage_reg  <= ENGAGE_RESET;
            release_reg <= RELEASE_RESET;
        end else begin
            mop_d_reg <= cmd.mop;
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_TARGET:  target_reg  <= $signed(cfg_data);
                    CFG_ENGAGE:  engage_reg  <= cfg_data[14:0];
                    CFG_RELEASE: release_reg <= cfg_data[14:0];
                    default: ;
                endcase
            end
            if (cmd.finish && !degen_reg) begin
                flag_reg <= flag_next;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            wx_reg    <= $signed(s_tdata[15:0]);
            wy_reg    <= $signed(s_tdata[31:16]);
            wz_reg    <= $signed(s_tdata[47:32]);
            ux_reg    <= $signed(s_tdata[63:48]);
            uy_reg    <= $signed(s_tdata[79:64]);
            uz_reg    <= $signed(s_tdata[95:80]);
            degen_reg <= sts.degen_in;
        end

        prod_reg <= $signed(mul_p[63:0]);

        case (mop_d_reg)
            MOP_WZWX: p0_reg   <= 32'(-prod_reg);
            MOP_WZWY: p1_reg   <= 32'(-prod_reg);
            MOP_WXWX: p2_reg   <= 33'(prod_reg);
            MOP_WYWY: p2_reg   <= p2_reg + 33'(prod_reg);
            MOP_P0SQ: acc_reg  <= $unsigned(prod_reg);
            MOP_P1SQ: acc_reg  <= acc_reg + $unsigned(prod_reg);
            MOP_P2SQ: acc_reg  <= acc_reg + $unsigned(prod_reg);
            MOP_UYWZ: v0_reg   <= 33'(prod_reg);
            MOP_UZWY: v0_reg   <= v0_reg - 33'(prod_reg);
            MOP_UZWX: v1_reg   <= 33'(prod_reg);
            MOP_UXWZ: v1_reg   <= v1_reg - 33'(prod_reg);
            MOP_UXWY: v2_reg   <= 33'(prod_reg);
            MOP_UYWX: v2_reg   <= v2_reg - 33'(prod_reg);
            MOP_T0U0: dacc_reg <= DACC_W'(prod_reg);
            MOP_T1U1: dacc_reg <= dacc_reg + DACC_W'(prod_reg);
            MOP_T2U2: dacc_reg <= dacc_reg + DACC_W'(prod_reg);
            MOP_T0V0: cacc_reg <= CACC_W'(prod_reg);
            MOP_T1V1: cacc_reg <= cacc_reg + CACC_W'(prod_reg);
            MOP_T2V2: cacc_reg <= cacc_reg + CACC_W'(prod_reg);
            default: ;
        endcase

        if (cmd.mop == MOP_XCLAMP) begin
            x_reg <= T_W'(x_clamp);
        end

        if (cmd.div_load) begin
            div_neg_reg <= div_neg;
        end
        if (cmd.t_write) begin
            t_reg[cmd.div_idx] <= t_new;
        end

        if (cmd.cordic_load) begin
            if (x_reg < 0) begin
                cx_reg <= s_val;
                cy_reg <= -CRD_W'(x_reg);
                z_reg  <= RIGHT_ANGLE;
            end else begin
                cx_reg <= CRD_W'(x_reg);
                cy_reg <= s_val;
                z_reg  <= 32'sd0;
            end
        end else if (cmd.cordic_step) begin
            if (cy_reg > 0) begin
                cx_reg <= cx_reg + cy_sh;
                cy_reg <= cy_reg - cx_sh;
                z_reg  <= z_reg + atan_entry(cmd.step);
            end else begin
                cx_reg <= cx_reg - cy_sh;
                cy_reg <= cy_reg + cx_sh;
                z_reg  <= z_reg - atan_entry(cmd.step);
            end
        end

        if (cmd.angle_load) begin
            tilt_reg <= (cacc_reg > 0) ? $signed(ang_mag) : -$signed(ang_mag);
        end

        if (cmd.finish) begin
            if (degen_reg) begin
                out_tilt_reg  <= 16'sd0;
                out_bal_reg   <= flag_reg;
                out_estop_reg <= 1'b0;
                out_degen_reg <= 1'b1;
            end else begin
                out_tilt_reg  <= tilt_reg;
                out_bal_reg   <= flag_next;
                out_estop_reg <= flag_reg && !flag_next;
                out_degen_reg <= 1'b0;
            end
        end
    end

    assign m_tdata = {5'd0, out_degen_reg, out_estop_reg, out_bal_reg, out_tilt_reg};

endmodule
`default_nettype wire

@@ src/tabq_ctrl.sv @@
`default_nettype none
module tabq_ctrl
    import tabq_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_tvalid,
    output logic           s_tready,
    output logic           m_tvalid,
    input  wire logic      m_tready,
    input  wire tabq_sts_t sts,
    output tabq_cmd_t      cmd
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_MUL_A, ST_LOAD_N, ST_SQRT_N, ST_DIV_LOAD, ST_DIV_RUN, ST_DIV_WR,
        ST_MUL_B, ST_LOAD_S, ST_SQRT_S, ST_CORDIC_LOAD, ST_CORDIC_RUN, ST_ANGLE,
        ST_FINISH
    } state_t;

    state_t     state_reg, state_next;
    mop_t       mop_reg, mop_next;
    logic [4:0] cnt_reg, cnt_next;
    logic [1:0] idx_reg, idx_next;
    logic       m_tvalid_reg, m_tvalid_next;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        state_next    = state_reg;
        mop_next      = mop_reg;
        cnt_next      = cnt_reg;
        idx_next      = idx_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        cmd           = '0;
        cmd.mop       = MOP_NONE;
        cmd.step      = cnt_reg;
        cmd.div_idx   = idx_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    mop_next   = MOP_WZWX;
                    state_next = sts.degen_in ? ST_FINISH : ST_MUL_A;
                end
            end
            ST_MUL_A: begin
                cmd.mop  = mop_reg;
                mop_next = mop_t'(mop_reg + 5'd1);
                if (mop_reg == MOP_A_END) begin
                    state_next = ST_LOAD_N;
                end
            end
            ST_LOAD_N: begin
                cmd.sqrt_load = 1'b1;
                cnt_next      = '0;
                state_next    = ST_SQRT_N;
            end
            ST_SQRT_N: begin
                cmd.sqrt_step = 1'b1;
                cnt_next      = cnt_reg + 5'd1;
                if (cnt_reg == 5'(SQRT_STEPS - 1)) begin
                    idx_next   = 2'd0;
                    state_next = ST_DIV_LOAD;
                end
            end
            ST_DIV_LOAD: begin
                cmd.div_load = 1'b1;
                cnt_next     = '0;
                state_next   = ST_DIV_RUN;
            end
            ST_DIV_RUN: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 5'd1;
                if (cnt_reg == 5'(DIV_STEPS - 1)) begin
                    state_next = ST_DIV_WR;
                end
            end
            ST_DIV_WR: begin
                cmd.t_write = 1'b1;
                if (idx_reg == 2'd2) begin
                    mop_next   = MOP_UYWZ;
                    state_next = ST_MUL_B;
                end else begin
                    idx_next   = idx_reg + 2'd1;
                    state_next = ST_DIV_LOAD;
                end
            end
            ST_MUL_B: begin
                cmd.mop  = mop_reg;
                mop_next = mop_t'(mop_reg + 5'd1);
                if (mop_reg == MOP_XX) begin
                    state_next = ST_LOAD_S;
                end
            end
            ST_LOAD_S: begin
                cmd.sqrt_load  = 1'b1;
                cmd.sqrt_sel_s = 1'b1;
                cnt_next       = '0;
                state_next     = ST_SQRT_S;
            end
            ST_SQRT_S: begin
                cmd.sqrt_step = 1'b1;
                cnt_next      = cnt_reg + 5'd1;
                if (cnt_reg == 5'(SQRT_STEPS - 1)) begin
                    state_next = ST_CORDIC_LOAD;
                end
            end
            ST_CORDIC_LOAD: begin
                cmd.cordic_load = 1'b1;
                cnt_next        = '0;
                state_next      = ST_CORDIC_RUN;
            end
            ST_CORDIC_RUN: begin
                cmd.cordic_step = 1'b1;
                cnt_next        = cnt_reg + 5'd1;
                if (cnt_reg == 5'(CORDIC_STEPS - 1)) begin
                    state_next = ST_ANGLE;
                end
            end
            ST_ANGLE: begin
                cmd.angle_load = 1'b1;
                state_next     = ST_FINISH;
            end
            ST_FINISH: begin
                if (!m_tvalid_reg || m_tready) begin
                    cmd.finish    = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            mop_reg      <= MOP_NONE;
            cnt_reg      <= '0;
            idx_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            mop_reg      <= mop_next;
            cnt_reg      <= cnt_next;
            idx_reg      <= idx_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second transfer taken while an item is in flight");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |-> (!m_tvalid_reg || m_tready))
        else $error("result register overwritten before transfer");

    a_wait_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINISH && m_tvalid_reg && !m_tready) |=> state_reg == ST_FINISH)
        else $error("finished item dropped while output stalled");

    a_cordic_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CORDIC_RUN) |-> (cnt_reg < 5'(CORDIC_STEPS)))
        else $error("CORDIC step beyond arctan table");

endmodule
`default_nettype wire

@@ src/tilt_angle_balance_qualifier.sv @@
// The result is registered in the finish state once the output slot is free; a
// vertical wheel axis goes from the input transfer straight to the finish state.
// Throughput: one item at a time (s_tready only while idle), set by the two 32-step
// square roots and three 16-step divisions plus 16 CORDIC steps on shared units.
// Reset (aresetn, synchronous, active low): idle, not balancing, configuration registers to defaults.
`default_nettype none
module tilt_angle_balance_qualifier
    import tabq_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [95:0] s_tdata,   // wheel_x, wheel_y, wheel_z, up_x, up_y, up_z
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [23:0] m_tdata,   // tilt_angle, balancing, stop_pulse, degenerate
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    tabq_cmd_t cmd;
    tabq_sts_t sts;

    tabq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    tabq_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .s_tdata   (s_tdata),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule
`default_nettype wire
